>>> src/ecg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecg_pkg: shared definitions for the exponential chirp generator
// widths, register indexes, sequencer states and the quarter-wave cosine rom
// ----------------------------------------------------------------------------
package ecg_pkg;

   // sweep length counter and phase table resolution
   localparam int COUNT_BITS = 24;
   localparam int PHASE_BITS = 12;

   // field widths
   localparam int FREQ_W     = 32;  // q16.16 hertz
   localparam int GROWTH_W   = 32;  // q2.30 ratio
   localparam int GAIN_W     = 32;  // signed q8.24
   localparam int LIMIT_W    = 24;
   localparam int EXC_W      = 16;  // signed q1.15
   localparam int CSR_ADDR_W = 8;
   localparam int CSR_DATA_W = 32;

   // internal arithmetic
   localparam int CUR_FREQ_W   = 56;                  // q16.40 hertz
   localparam int FRAC_SHIFT   = CUR_FREQ_W - FREQ_W; // q16.40 to q16.16
   localparam int MUL_BITS     = 32;                  // multiplier operand bits
   localparam int MUL_CNT_W    = $clog2(MUL_BITS);
   localparam int GROW_SHIFT   = 30;
   localparam int GUARD_W      = MUL_BITS - GROW_SHIFT;
   localparam int PHASE_W      = 40;                  // turn fraction q0.40
   localparam int UNIT_SHIFT   = 16;                  // one hertz in q16.16
   localparam int QUARTER_BITS = PHASE_BITS - 2;
   localparam int QUARTER_SIZE = 1 << QUARTER_BITS;
   localparam int ROM_DEPTH    = QUARTER_SIZE + 1;
   localparam int ROM_ADDR_W   = QUARTER_BITS + 1;
   localparam int ROM_W        = 15;

   // rom build constants
   localparam longint ONE_Q30     = 64'sd1 << 30;
   localparam longint HALF_PI_Q30 = 64'sd1686629713;
   localparam longint COS_FULL    = 64'sd32767;

   typedef logic [COUNT_BITS-1:0]       count_type;
   typedef logic [FREQ_W-1:0]           freq_type;
   typedef logic [CUR_FREQ_W-1:0]       cur_freq_type;
   typedef logic [GROWTH_W-1:0]         growth_type;
   typedef logic [GAIN_W-1:0]           gain_type;
   typedef logic signed [EXC_W-1:0]     exc_type;
   typedef logic [CSR_ADDR_W-1:0]       csr_addr_type;
   typedef logic [CSR_DATA_W-1:0]       csr_data_type;
   typedef logic [ROM_W-1:0]            rom_word_type;
   typedef logic [ROM_ADDR_W-1:0]       rom_addr_type;
   typedef rom_word_type                rom_array_type [ROM_DEPTH];

   // configuration register indexes
   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_START_FREQ   = 8'd0,
      CSR_GROWTH       = 8'd1,
      CSR_PHASE_GAIN   = 8'd2,
      CSR_COUNT_LIMIT  = 8'd3
   } csr_index_type;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GROW,
      ST_GROW_END,
      ST_DIFF,
      ST_PHASE,
      ST_LOOKUP,
      ST_SCALE,
      ST_FINISH
   } state_type;

   // quarter-wave cosine table, q30 taylor series to the tenth power
   function automatic rom_array_type build_cos_rom();
      rom_array_type rom;
      longint x;
      longint y;
      longint y2;
      longint t;
      for (int i = 0; i < ROM_DEPTH; i++) begin
         x  = longint'(i) * (ONE_Q30 / QUARTER_SIZE);
         y  = (x * HALF_PI_Q30) / ONE_Q30;
         y2 = (y * y) / ONE_Q30;
         t  = ONE_Q30 - y2 / 90;
         t  = ONE_Q30 - ((y2 / 56) * t) / ONE_Q30;
         t  = ONE_Q30 - ((y2 / 30) * t) / ONE_Q30;
         t  = ONE_Q30 - ((y2 / 12) * t) / ONE_Q30;
         t  = ONE_Q30 - ((y2 / 2) * t) / ONE_Q30;
         if (t < 0) begin
            rom[i] = '0;
         end else begin
            t = (t * COS_FULL + (ONE_Q30 / 2)) / ONE_Q30;
            rom[i] = (t > COS_FULL) ? ROM_W'(COS_FULL) : ROM_W'(t);
         end
      end
      return rom;
   endfunction

endpackage

>>> src/ecg_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ecg channel interfaces
// sample tick request, excitation response and register write channels
// ----------------------------------------------------------------------------

// sample tick request
interface ecg_req_if import ecg_pkg::*; ();
   logic valid;
   logic ready;
   logic restart;

   modport source (output valid, output restart, input ready);
   modport sink   (input valid, input restart, output ready);
endinterface

// excitation response
interface ecg_rsp_if import ecg_pkg::*; ();
   logic     valid;
   logic     ready;
   exc_type  excitation;
   freq_type frequency;
   logic     active;

   modport source (output valid, output excitation, output frequency, output active,
                   input ready);
   modport sink   (input valid, input excitation, input frequency, input active,
                   output ready);
endinterface

// register write channel
interface ecg_csr_if import ecg_pkg::*; ();
   logic         valid;
   logic         ready;
   csr_addr_type index;
   csr_data_type data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

>>> src/exponential_chirp_generator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// exponential_chirp_generator_top: exponential sine sweep excitation source
// one sample per tick item: frequency by recursion, phase, cosine rom lookup
// ----------------------------------------------------------------------------
// sweep sample: states grow, grow_end, diff, phase, lookup, scale, finish, then the
//   next accept (the first sample skips grow and grow_end); grow and phase are
//   two passes of a bit-serial shift-add multiplier (growth ratio, then phase gain)
// restart, finished or limit ticks go straight to finish, which waits for out_free
// a result waiting in the output register does not block the next accept
// synchronous active-high reset: registers to defaults, sweep count cleared
module exponential_chirp_generator_top import ecg_pkg::*; (
   input  logic clock,
   input  logic reset,
   ecg_req_if.sink   req_bus,
   ecg_rsp_if.source rsp_bus,
   ecg_csr_if.sink   csr_bus
);

   localparam rom_array_type COS_ROM = build_cos_rom();
   localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(MUL_BITS - 1);

   // configuration registers
   freq_type   start_ff;
   growth_type growth_ff;
   gain_type   gain_ff;
   count_type  limit_ff;

   // sweep state
   state_type    state_ff, state_in;
   count_type    count_ff, count_in;
   cur_freq_type cur_freq_ff, cur_freq_in;
   logic         done_ff, done_in;

   // serial multiplier
   cur_freq_type           mcand_ff, mcand_in;
   logic [MUL_BITS-1:0]    mplier_ff, mplier_in;
   cur_freq_type           acc_ff, acc_in;
   logic [MUL_BITS-1:0]    lo_ff, lo_in;
   logic [MUL_CNT_W-1:0]   bit_cnt_ff, bit_cnt_in;

   // result assembly
   freq_type     freq_res_ff, freq_res_in;
   exc_type      exc_res_ff, exc_res_in;
   logic         act_res_ff, act_res_in;
   logic         neg_ff, neg_in;
   rom_word_type rom_rd_ff;
   rom_addr_type rom_addr;

   // output register
   logic     rsp_valid_ff, rsp_valid_in;
   exc_type  rsp_exc_ff;
   freq_type rsp_freq_ff;
   logic     rsp_act_ff;

   // handshake and decode
   logic req_fire;
   logic out_free;
   logic out_load;
   logic tick_idle;
   logic first_sample;

   assign out_free     = !rsp_valid_ff || rsp_bus.ready;
   assign req_fire     = req_bus.valid && req_bus.ready;
   assign tick_idle    = req_bus.restart || done_ff || (count_ff >= limit_ff);
   assign first_sample = (count_ff == '0);

   // register writes, always accepted
   assign csr_bus.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff  <= freq_type'(65536);
         growth_ff <= growth_type'(32'h4000_0000);
         gain_ff   <= '0;
         limit_ff  <= '0;
      end else if (csr_bus.valid) begin
         case (csr_bus.index)
            CSR_START_FREQ:  start_ff  <= csr_bus.data[FREQ_W-1:0];
            CSR_GROWTH:      growth_ff <= csr_bus.data[GROWTH_W-1:0];
            CSR_PHASE_GAIN:  gain_ff   <= csr_bus.data[GAIN_W-1:0];
            CSR_COUNT_LIMIT: limit_ff  <= count_type'(csr_bus.data[LIMIT_W-1:0]);
            default: ;
         endcase
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (tick_idle) begin
                  state_in = ST_FINISH;
               end else if (first_sample) begin
                  state_in = ST_DIFF;
               end else begin
                  state_in = ST_GROW;
               end
            end
         end
         ST_GROW: begin
            if (bit_cnt_ff == MUL_LAST) state_in = ST_GROW_END;
         end
         ST_GROW_END: state_in = ST_DIFF;
         ST_DIFF:     state_in = ST_PHASE;
         ST_PHASE: begin
            if (bit_cnt_ff == MUL_LAST) state_in = ST_LOOKUP;
         end
         ST_LOOKUP:   state_in = ST_SCALE;
         ST_SCALE:    state_in = ST_FINISH;
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default:     state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_bus.ready = 1'b0;
      out_load      = 1'b0;
      case (state_ff)
         ST_IDLE:   req_bus.ready = 1'b1;
         ST_FINISH: out_load      = out_free;
         default: ;
      endcase
   end

   // datapath
   always_comb begin
      logic [CUR_FREQ_W:0]   grow_sum;
      cur_freq_type          grow_add;
      logic [PHASE_W-1:0]    phase_add;
      logic [PHASE_W-1:0]    phase_sum;
      logic [FREQ_W:0]       diff;
      freq_type              f16;
      logic                  sat;
      logic [PHASE_BITS-1:0] phase_idx;
      logic [1:0]            quad;
      logic [ROM_W+UNIT_SHIFT-1:0] scale_prod;
      rom_word_type          mag;
      logic [EXC_W-1:0]      mag_ext;

      count_in    = count_ff;
      cur_freq_in = cur_freq_ff;
      done_in     = done_ff;
      mcand_in    = mcand_ff;
      mplier_in   = mplier_ff;
      acc_in      = acc_ff;
      lo_in       = lo_ff;
      bit_cnt_in  = bit_cnt_ff;
      freq_res_in = freq_res_ff;
      exc_res_in  = exc_res_ff;
      act_res_in  = act_res_ff;
      neg_in      = neg_ff;

      grow_add  = mplier_ff[0] ? mcand_ff : '0;
      grow_sum  = {1'b0, acc_ff} + {1'b0, grow_add};
      phase_add = mplier_ff[0] ? mcand_ff[PHASE_W-1:0] : '0;
      // the top multiplier bit carries negative weight
      phase_sum = (bit_cnt_ff == MUL_LAST) ? acc_ff[PHASE_W-1:0] - phase_add
                                           : acc_ff[PHASE_W-1:0] + phase_add;
      f16       = cur_freq_ff[CUR_FREQ_W-1:FRAC_SHIFT];
      diff      = {1'b0, f16} - {1'b0, start_ff};
      sat       = |acc_ff[CUR_FREQ_W-1 -: GUARD_W];
      phase_idx = acc_ff[PHASE_W-1 -: PHASE_BITS];
      quad      = phase_idx[PHASE_BITS-1 -: 2];
      scale_prod = (ROM_W+UNIT_SHIFT)'(rom_rd_ff)
                   * (ROM_W+UNIT_SHIFT)'(freq_res_ff[UNIT_SHIFT-1:0]);
      mag       = (freq_res_ff[FREQ_W-1:UNIT_SHIFT] == '0)
                  ? scale_prod[ROM_W+UNIT_SHIFT-1:UNIT_SHIFT] : rom_rd_ff;
      mag_ext   = {{(EXC_W-ROM_W){1'b0}}, mag};

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               // zero result unless a sweep sample is due
               freq_res_in = '0;
               exc_res_in  = '0;
               act_res_in  = 1'b0;
               if (req_bus.restart) begin
                  count_in    = '0;
                  cur_freq_in = '0;
                  done_in     = 1'b0;
               end else if (done_ff) begin
                  done_in = 1'b1;
               end else if (count_ff >= limit_ff) begin
                  done_in = 1'b1;
               end else begin
                  count_in = count_ff + 1'b1;
                  if (first_sample) begin
                     cur_freq_in = {start_ff, {FRAC_SHIFT{1'b0}}};
                  end else begin
                     mcand_in   = cur_freq_ff;
                     mplier_in  = growth_ff;
                     acc_in     = '0;
                     bit_cnt_in = '0;
                  end
               end
            end
         end
         ST_GROW: begin
            // shift-add, low product bits leave through lo
            acc_in     = grow_sum[CUR_FREQ_W:1];
            lo_in      = {grow_sum[0], lo_ff[MUL_BITS-1:1]};
            mplier_in  = mplier_ff >> 1;
            bit_cnt_in = bit_cnt_ff + 1'b1;
         end
         ST_GROW_END: begin
            // drop the q30 fraction, saturate at full scale
            cur_freq_in = sat ? '1
                              : {acc_ff[CUR_FREQ_W-GUARD_W-1:0], lo_ff[MUL_BITS-1 -: GUARD_W]};
         end
         ST_DIFF: begin
            // sign-extended frequency rise times the phase gain
            mcand_in    = {{(CUR_FREQ_W-FREQ_W-1){diff[FREQ_W]}}, diff};
            mplier_in   = gain_ff;
            acc_in      = '0;
            bit_cnt_in  = '0;
            freq_res_in = f16;
         end
         ST_PHASE: begin
            // only the turn fraction is kept
            acc_in     = cur_freq_type'(phase_sum);
            mcand_in   = mcand_ff << 1;
            mplier_in  = mplier_ff >> 1;
            bit_cnt_in = bit_cnt_ff + 1'b1;
         end
         ST_LOOKUP: begin
            neg_in = quad[1] ^ quad[0];
         end
         ST_SCALE: begin
            exc_res_in = neg_ff ? signed'(-mag_ext) : signed'(mag_ext);
            act_res_in = 1'b1;
         end
         default: ;
      endcase
   end

   // quadrant fold into the table address
   always_comb begin
      logic [PHASE_BITS-1:0] idx;
      idx = acc_ff[PHASE_W-1 -: PHASE_BITS];
      if (idx[QUARTER_BITS]) begin
         rom_addr = ROM_ADDR_W'(QUARTER_SIZE) - {1'b0, idx[QUARTER_BITS-1:0]};
      end else begin
         rom_addr = {1'b0, idx[QUARTER_BITS-1:0]};
      end
   end

   // registered table read
   always_ff @(posedge clock) begin
      if (state_ff == ST_LOOKUP) rom_rd_ff <= COS_ROM[rom_addr];
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         cur_freq_ff  <= '0;
         done_ff      <= 1'b0;
         bit_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         cur_freq_ff  <= cur_freq_in;
         done_ff      <= done_in;
         bit_cnt_ff   <= bit_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      mcand_ff    <= mcand_in;
      mplier_ff   <= mplier_in;
      acc_ff      <= acc_in;
      lo_ff       <= lo_in;
      freq_res_ff <= freq_res_in;
      exc_res_ff  <= exc_res_in;
      act_res_ff  <= act_res_in;
      neg_ff      <= neg_in;
      if (out_load) begin
         rsp_exc_ff  <= exc_res_ff;
         rsp_freq_ff <= freq_res_ff;
         rsp_act_ff  <= act_res_ff;
      end
   end

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.excitation = rsp_exc_ff;
   assign rsp_bus.frequency  = rsp_freq_ff;
   assign rsp_bus.active     = rsp_act_ff;

endmodule
